### hw/rtl/wcfc_pkg.sv
// Package for the word case frame converter: state and result types,
// style, phase and error codes, character constants and helper functions.
// Depends on nothing.
`default_nettype none

package wcfc_pkg;

    localparam int WordLimitDefault      = 10;
    localparam int SeparatorLimitDefault = 15;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_SNAKE  = 2'd1;
    localparam logic [1:0] MODE_CAMEL  = 2'd2;
    localparam logic [1:0] MODE_PASCAL = 2'd3;

    localparam logic [2:0] PH_CMD   = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_WORD  = 3'd2;
    localparam logic [2:0] PH_ERR   = 3'd3;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_DATA   = 2'd1;
    localparam logic [1:0] ERR_OPCODE = 2'd2;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_DATA   = 2'd1;
    localparam logic [1:0] STS_OPCODE = 2'd2;

    localparam logic [7:0] CH_SNAKE  = 8'h53;  // 'S'
    localparam logic [7:0] CH_CAMEL  = 8'h43;  // 'C'
    localparam logic [7:0] CH_PASCAL = 8'h50;  // 'P'
    localparam logic [7:0] CH_UNDER  = 8'h5F;  // '_'
    localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
    localparam logic [7:0] CH_E      = 8'h45;  // 'E'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE    = 8'h31;  // '1'
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [4:0] WORDS_MAX = 5'd31;

    typedef struct packed {
        logic [1:0] style_mode;
        logic [2:0] phase;
        logic [3:0] letters_in_word;
        logic [4:0] words_seen;
        logic [1:0] error_kind;
    } t_state;

    typedef struct packed {
        logic [7:0] out_char;
        logic       error_reply;
        logic       last;
        logic [1:0] status;
    } t_result;

    // Up to three result words caused by one input word, issued from item 0.
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     items;
    } t_group;

    localparam t_state STATE_RESET = '{
        style_mode: MODE_NONE, phase: PH_CMD, letters_in_word: 4'd0,
        words_seen: 5'd0, error_kind: ERR_NONE};

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    // Case of a letter is bit 5 of its code.
    function automatic logic [7:0] word_initial(input logic [7:0] c, input logic low);
        logic [7:0] r;
        r = c;
        if (low && is_upper(c)) begin
            r = c | 8'h20;
        end else if (!low && is_lower(c)) begin
            r = c & 8'hDF;
        end
        return r;
    endfunction

    function automatic t_result mk_result(input logic [7:0] ch, input logic er,
                                          input logic lst, input logic [1:0] st);
        t_result r;
        r.out_char    = ch;
        r.error_reply = er;
        r.last        = lst;
        r.status      = st;
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/wcfc_if.sv
// Valid/ready channel interfaces for the word case frame converter:
// one for input words (symbol, frame end) and one for result words.
// Depends on nothing.
`default_nettype none

interface wcfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       frame_end;

    modport source (output valid, output symbol, output frame_end, input ready);
    modport sink   (input valid, input symbol, input frame_end, output ready);
endinterface

interface wcfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       error_reply;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output out_char, output error_reply,
                    output last, output status, input ready);
    modport sink   (input valid, input out_char, input error_reply,
                    input last, input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/wcfc_step.sv
// Conversion step: next frame state and the result group for one input word.
// Depends on wcfc_pkg.
`default_nettype none

module wcfc_step #(
    parameter int WORD_LIMIT      = wcfc_pkg::WordLimitDefault,
    parameter int SEPARATOR_LIMIT = wcfc_pkg::SeparatorLimitDefault
) (
    input  wcfc_pkg::t_state i_state,
    input  logic [7:0]       i_symbol,
    input  logic             i_frame_end,
    output wcfc_pkg::t_state o_state,
    output wcfc_pkg::t_group o_group
);
    import wcfc_pkg::*;

    logic [4:0] words_inc;
    logic [4:0] letters_inc;
    logic [1:0] end_err;
    logic       first_low;

    assign words_inc   = (i_state.words_seen < WORDS_MAX) ? i_state.words_seen + 5'd1
                                                          : i_state.words_seen;
    assign letters_inc = {1'b0, i_state.letters_in_word} + 5'd1;
    assign first_low   = (i_state.style_mode == MODE_SNAKE) ||
                         ((i_state.words_seen == 5'd0) && (i_state.style_mode == MODE_CAMEL));

    always_comb begin
        o_state       = i_state;
        o_group       = '0;
        end_err       = ERR_NONE;

        if (i_frame_end) begin
            unique case (i_state.phase)
                PH_CMD:   end_err = ERR_OPCODE;
                PH_START: end_err = ERR_DATA;
                PH_ERR:   end_err = i_state.error_kind;
                default:  end_err = ERR_NONE;
            endcase
            if (end_err == ERR_NONE) begin
                o_group.count    = 2'd1;
                o_group.items[0] = mk_result(CH_NUL, 1'b0, 1'b1, STS_OK);
            end else begin
                o_group.count    = 2'd3;
                o_group.items[0] = mk_result(CH_E, 1'b1, 1'b0, STS_OK);
                o_group.items[1] = mk_result(CH_ZERO, 1'b1, 1'b0, STS_OK);
                o_group.items[2] = (end_err == ERR_OPCODE)
                                 ? mk_result(CH_ONE, 1'b1, 1'b1, STS_OPCODE)
                                 : mk_result(CH_ZERO, 1'b1, 1'b1, STS_DATA);
            end
            o_state = STATE_RESET;
        end else begin
            unique case (i_state.phase)
                PH_CMD: begin
                    o_group.count    = 2'd1;
                    o_group.items[0] = mk_result(i_symbol, 1'b0, 1'b0, STS_OK);
                    o_state.phase    = PH_START;
                    case (i_symbol)
                        CH_SNAKE:  o_state.style_mode = MODE_SNAKE;
                        CH_CAMEL:  o_state.style_mode = MODE_CAMEL;
                        CH_PASCAL: o_state.style_mode = MODE_PASCAL;
                        default: begin
                            o_state.phase      = PH_ERR;
                            o_state.error_kind = ERR_OPCODE;
                        end
                    endcase
                end
                PH_START: begin
                    if (is_upper(i_symbol) || is_lower(i_symbol)) begin
                        o_group.count    = 2'd1;
                        o_group.items[0] = mk_result(word_initial(i_symbol, first_low),
                                                     1'b0, 1'b0, STS_OK);
                        o_state.letters_in_word = 4'd1;
                        o_state.phase           = PH_WORD;
                    end else begin
                        o_state.phase      = PH_ERR;
                        o_state.error_kind = ERR_DATA;
                    end
                end
                PH_WORD: begin
                    if (is_lower(i_symbol)) begin
                        if (letters_inc >= 5'(WORD_LIMIT)) begin
                            o_state.phase      = PH_ERR;
                            o_state.error_kind = ERR_DATA;
                        end else begin
                            o_state.letters_in_word = letters_inc[3:0];
                            o_group.count    = 2'd1;
                            o_group.items[0] = mk_result(i_symbol, 1'b0, 1'b0, STS_OK);
                        end
                    end else begin
                        o_state.words_seen = words_inc;
                        if (words_inc > 5'(SEPARATOR_LIMIT)) begin
                            o_state.phase      = PH_ERR;
                            o_state.error_kind = ERR_DATA;
                        end else if ((i_symbol == CH_UNDER) || (i_symbol == CH_SPACE)) begin
                            if (i_state.style_mode == MODE_SNAKE) begin
                                o_group.count    = 2'd1;
                                o_group.items[0] = mk_result(CH_UNDER, 1'b0, 1'b0, STS_OK);
                            end
                            o_state.letters_in_word = 4'd0;
                            o_state.phase           = PH_START;
                        end else if (is_upper(i_symbol)) begin
                            if (i_state.style_mode == MODE_SNAKE) begin
                                o_group.count    = 2'd2;
                                o_group.items[0] = mk_result(CH_UNDER, 1'b0, 1'b0, STS_OK);
                                o_group.items[1] = mk_result(word_initial(i_symbol, 1'b1),
                                                             1'b0, 1'b0, STS_OK);
                            end else begin
                                o_group.count    = 2'd1;
                                o_group.items[0] = mk_result(word_initial(i_symbol, 1'b0),
                                                             1'b0, 1'b0, STS_OK);
                            end
                            o_state.letters_in_word = 4'd1;
                        end else begin
                            o_state.phase      = PH_ERR;
                            o_state.error_kind = ERR_DATA;
                        end
                    end
                end
                default: begin
                    // Error phase: input is dropped until the frame ends.
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/word_case_frame_converter.sv
// Top level of the word case frame converter: input register, frame state,
// result group register and the output sequencer.
// Depends on wcfc_pkg, wcfc_if (wcfc_in_if, wcfc_out_if) and wcfc_step.
`default_nettype none

// Channel   Direction  Payload                              Handshake
// i_sym     in         symbol[7:0], frame_end               valid/ready
// o_res     out        out_char[7:0], error_reply, last,    valid/ready
//                      status[1:0]
//
// An input word is taken into an input register and converted, once the
// result group register is empty or its final word leaves, into a group of
// zero to three result words; those are issued one per cycle from the result
// group register while the output is ready, so the rate is set by the
// result register draining its words. The path from input accept to the first
// result runs through the input register and the result group register.
// Synchronous active-low reset clears the frame state and both valid flags.
// A stall on the output holds the group; the input register still takes one
// more word and then holds ready low until the group has been handed on.

module word_case_frame_converter #(
    parameter int WORD_LIMIT      = wcfc_pkg::WordLimitDefault,
    parameter int SEPARATOR_LIMIT = wcfc_pkg::SeparatorLimitDefault
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wcfc_in_if.sink    i_sym,
    wcfc_out_if.source o_res
);
    import wcfc_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_symbol;
    logic       r_in_frame_end;

    // Frame state, advanced when the input register moves into the group.
    t_state     r_state;
    t_state     n_state;

    // Result group register and read pointer within it.
    t_group     n_group;
    t_result [2:0] r_items;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;

    logic in_fire;
    logic out_fire;
    logic last_take;
    logic can_load;
    logic load;

    wcfc_step #(
        .WORD_LIMIT      (WORD_LIMIT),
        .SEPARATOR_LIMIT (SEPARATOR_LIMIT)
    ) u_step (
        .i_state     (r_state),
        .i_symbol    (r_in_symbol),
        .i_frame_end (r_in_frame_end),
        .o_state     (n_state),
        .o_group     (n_group)
    );

    // The group may be replaced when it is empty or its final word leaves now.
    assign out_fire  = o_res.valid && o_res.ready;
    assign last_take = out_fire && (r_idx == (r_cnt - 2'd1));
    assign can_load  = (r_cnt == 2'd0) || last_take;
    assign load      = r_in_valid && can_load;

    assign i_sym.ready = !r_in_valid || can_load;
    assign in_fire     = i_sym.valid && i_sym.ready;

    assign o_res.valid       = (r_cnt != 2'd0);
    assign o_res.out_char    = r_items[r_idx].out_char;
    assign o_res.error_reply = r_items[r_idx].error_reply;
    assign o_res.last        = r_items[r_idx].last;
    assign o_res.status      = r_items[r_idx].status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= STATE_RESET;
            r_cnt      <= 2'd0;
            r_idx      <= 2'd0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (can_load) begin
                r_in_valid <= 1'b0;
            end

            if (load) begin
                r_state <= n_state;
                r_cnt   <= n_group.count;
                r_idx   <= 2'd0;
            end else if (last_take) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else if (out_fire) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_symbol    <= i_sym.symbol;
            r_in_frame_end <= i_sym.frame_end;
        end
        if (load) begin
            r_items <= n_group.items;
        end
    end

endmodule

`default_nettype wire
